// ===== hdl/powerpc_integer_execute_unit_assert.svh =====
// assertion macros for the integer execute unit
`ifndef POWERPC_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define POWERPC_INTEGER_EXECUTE_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PIEU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define PIEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/pieu_pkg.sv =====
// package: opcodes, extended opcodes, condition codes, result word type and helper functions
`timescale 1ns / 1ps
package pieu_pkg;
    localparam logic [5:0] OP_MULLI = 6'd7;
    localparam logic [5:0] OP_CMPLI = 6'd10;
    localparam logic [5:0] OP_CMPI = 6'd11;
    localparam logic [5:0] OP_ADDIC = 6'd12;
    localparam logic [5:0] OP_ADDICR = 6'd13;
    localparam logic [5:0] OP_ADDI = 6'd14;
    localparam logic [5:0] OP_ADDIS = 6'd15;
    localparam logic [5:0] OP_RLWIMI = 6'd20;
    localparam logic [5:0] OP_RLWINM = 6'd21;
    localparam logic [5:0] OP_RLWNM = 6'd23;
    localparam logic [5:0] OP_ORI = 6'd24;
    localparam logic [5:0] OP_ORIS = 6'd25;
    localparam logic [5:0] OP_XORI = 6'd26;
    localparam logic [5:0] OP_XORIS = 6'd27;
    localparam logic [5:0] OP_ANDI = 6'd28;
    localparam logic [5:0] OP_ANDIS = 6'd29;
    localparam logic [5:0] OP_X = 6'd31;

    localparam logic [9:0] XO_CMP = 10'd0;
    localparam logic [9:0] XO_CMPL = 10'd32;
    localparam logic [9:0] XO_SUBF = 10'd40;
    localparam logic [9:0] XO_NEG = 10'd104;
    localparam logic [9:0] XO_ADD = 10'd266;
    localparam logic [9:0] XO_MULLW = 10'd235;
    localparam logic [9:0] XO_MULHWU = 10'd11;
    localparam logic [9:0] XO_AND = 10'd28;
    localparam logic [9:0] XO_OR = 10'd444;
    localparam logic [9:0] XO_XOR = 10'd316;
    localparam logic [9:0] XO_EXTSB = 10'd954;
    localparam logic [9:0] XO_EXTSH = 10'd922;
    localparam logic [9:0] XO_SLW = 10'd24;
    localparam logic [9:0] XO_SRW = 10'd536;
    localparam logic [9:0] XO_SRAW = 10'd792;
    localparam logic [9:0] XO_SRAWI = 10'd824;
    localparam logic [9:0] XO_CNTLZW = 10'd26;

    localparam logic [3:0] CR_LT = 4'b1000;
    localparam logic [3:0] CR_GT = 4'b0100;
    localparam logic [3:0] CR_EQ = 4'b0010;

    // result word, lowest field first in tdata
    typedef struct packed {
        logic        unhandled;
        logic        carry_value;
        logic        carry_written;
        logic [3:0]  cr_bits;
        logic [2:0]  cr_field;
        logic        cr_written;
        logic [31:0] reg_value;
        logic [4:0]  reg_index;
        logic        reg_written;
    } t_result;

    function automatic logic [3:0] f_compare(input logic [31:0] a, input logic [31:0] b,
                                             input logic is_signed);
        logic [31:0] x;
        logic [31:0] y;
        begin
            x = is_signed ? (a ^ 32'h8000_0000) : a;
            y = is_signed ? (b ^ 32'h8000_0000) : b;
            if (x < y) f_compare = CR_LT;
            else if (x > y) f_compare = CR_GT;
            else f_compare = CR_EQ;
        end
    endfunction

    function automatic logic [31:0] f_mask(input logic [4:0] mb, input logic [4:0] me);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] m;
        begin
            hi = 32'hFFFF_FFFF >> mb;
            lo = (me == 5'd31) ? 32'd0 : (32'hFFFF_FFFF >> (6'(me) + 6'd1));
            m = hi ^ lo;
            f_mask = (mb > me) ? ~m : m;
        end
    endfunction

    function automatic logic [31:0] f_rotl(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {v, v} << n;
            f_rotl = d[63:32];
        end
    endfunction

    function automatic logic [5:0] f_clz(input logic [31:0] v);
        logic [5:0] n;
        logic       done;
        begin
            n = 6'd0;
            done = 1'b0;
            for (int i = 31; i >= 0; i--) begin
                if (!done && !v[i]) n = n + 6'd1;
                else done = 1'b1;
            end
            f_clz = n;
        end
    endfunction
endpackage

// ===== hdl/powerpc_integer_execute_unit.sv =====
// top level: integer execute unit with register file memory
`timescale 1ns / 1ps
// Integer execute unit for 32-bit PowerPC instruction words. One word enters
// per cycle while the input is ready, and one result word leaves per
// instruction. Stage 1 registers the instruction while the general register
// file (a 32x32 synchronous memory read at three addresses, one copy per read
// port) returns rt, ra and rb. Stage 2 forwards the value the previous
// instruction writes back, executes, writes the memory and the carry/condition
// registers, and loads the output register. A two-entry output queue holds
// results under back-pressure; the input is ready while the queue has room for
// the new word and the word in stage 1, counting a result that leaves in the
// same cycle, so words flow back to back while the receiver keeps up. The
// memory clears to zero after reset, during which no word is accepted.
module powerpc_integer_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // instruction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // reg_written, reg_index, reg_value, cr_written, cr_field, cr_bits,
    // carry_written, carry_value, unhandled, zero fill
    output logic [55:0] m_axis_tdata
);
    import pieu_pkg::*;
    `include "powerpc_integer_execute_unit_assert.svh"

    // register file, one copy per read port
    logic [31:0] r_mem_t [32];
    logic [31:0] r_mem_a [32];
    logic [31:0] r_mem_b [32];
    logic [31:0] r_rd_t, r_rd_a, r_rd_b;

    // clearing sweep after reset
    logic [5:0]  r_clr;
    logic        clearing;

    // stage 1
    logic        r_v1;
    logic [31:0] r_ins;

    // last writeback for forwarding
    logic        r_fw_v;
    logic [4:0]  r_fw_idx;
    logic [31:0] r_fw_val;

    logic        r_carry;
    logic [31:0] r_cr;

    // output skid: two entries
    t_result     r_q0, r_q1;
    logic        r_q0_v, r_q1_v;
    logic [1:0]  r_cnt;

    logic        take, exec, pop;
    t_result     res;

    assign clearing = !r_clr[5];
    // room check counts the item already in stage 1 and a result leaving now
    assign s_axis_tready = !clearing &&
        (({1'b0, r_cnt} + {2'b00, r_v1}) < (3'd2 + {2'b00, pop}));
    assign take = s_axis_tvalid && s_axis_tready;
    assign exec = r_v1;
    assign pop = m_axis_tvalid && m_axis_tready;

    // field decode
    logic [5:0]  opcd;
    logic [4:0]  rt, ra, rb, mb, me;
    logic [9:0]  xo;
    logic        rc;
    logic [15:0] uimm;
    logic [31:0] simm, vs, va, vb, wval, rotv, mask, prod_lo, prod_hi;
    logic [63:0] prod;
    logic [31:0] mul_b;
    logic        wr, crw, caw, cav, unh, rec;
    logic [4:0]  widx;
    logic [2:0]  crf;
    logic [3:0]  crb;
    logic [31:0] sra_r;
    logic        sra_c;
    logic [5:0]  sh_n;
    logic [31:0] cr_mask;

    always_comb begin
        opcd = r_ins[31:26];
        rt = r_ins[25:21];
        ra = r_ins[20:16];
        rb = r_ins[15:11];
        mb = r_ins[10:6];
        me = r_ins[5:1];
        xo = r_ins[10:1];
        rc = r_ins[0];
        uimm = r_ins[15:0];
        simm = {{16{uimm[15]}}, uimm};
        // forward the previous writeback over the stale memory read
        vs = (r_fw_v && r_fw_idx == rt) ? r_fw_val : r_rd_t;
        va = (r_fw_v && r_fw_idx == ra) ? r_fw_val : r_rd_a;
        vb = (r_fw_v && r_fw_idx == rb) ? r_fw_val : r_rd_b;
    end

    always_comb begin
        mul_b = (opcd == OP_MULLI) ? simm : vb;
        prod = 64'(va) * 64'(mul_b);
        prod_lo = prod[31:0];
        prod_hi = prod[63:32];
        rotv = f_rotl(vs, (opcd == OP_RLWNM) ? vb[4:0] : rb);
        mask = f_mask(mb, me);
        sh_n = (xo == XO_SRAWI) ? {1'b0, rb} : vb[5:0];
        if (sh_n[5]) begin
            sra_r = {32{vs[31]}};
            sra_c = vs[31];
        end else begin
            sra_r = 32'($signed(vs) >>> sh_n[4:0]);
            sra_c = vs[31] && ((vs & ~(32'hFFFF_FFFF << sh_n[4:0])) != 32'd0);
        end
    end

    always_comb begin
        wr = 1'b0; widx = 5'd0; wval = 32'd0;
        crw = 1'b0; crf = 3'd0; crb = 4'd0;
        caw = 1'b0; cav = 1'b0; unh = 1'b0; rec = 1'b0;
        unique case (opcd)
            OP_MULLI: begin wr = 1'b1; widx = rt; wval = prod_lo; end
            OP_CMPLI: begin
                crw = 1'b1; crf = r_ins[25:23]; crb = f_compare(va, {16'd0, uimm}, 1'b0);
            end
            OP_CMPI: begin
                crw = 1'b1; crf = r_ins[25:23]; crb = f_compare(va, simm, 1'b1);
            end
            OP_ADDIC, OP_ADDICR: begin
                wr = 1'b1; widx = rt; wval = va + simm;
                caw = 1'b1; cav = (wval < simm);
                rec = (opcd == OP_ADDICR);
            end
            OP_ADDI: begin wr = 1'b1; widx = rt; wval = ((ra != 5'd0) ? va : 32'd0) + simm; end
            OP_ADDIS: begin
                wr = 1'b1; widx = rt; wval = ((ra != 5'd0) ? va : 32'd0) + {uimm, 16'd0};
            end
            OP_RLWIMI: begin
                wr = 1'b1; widx = ra; wval = (rotv & mask) | (va & ~mask); rec = rc;
            end
            OP_RLWINM, OP_RLWNM: begin wr = 1'b1; widx = ra; wval = rotv & mask; rec = rc; end
            OP_ORI: begin wr = 1'b1; widx = ra; wval = vs | {16'd0, uimm}; end
            OP_ORIS: begin wr = 1'b1; widx = ra; wval = vs | {uimm, 16'd0}; end
            OP_XORI: begin wr = 1'b1; widx = ra; wval = vs ^ {16'd0, uimm}; end
            OP_XORIS: begin wr = 1'b1; widx = ra; wval = vs ^ {uimm, 16'd0}; end
            OP_ANDI: begin wr = 1'b1; widx = ra; wval = vs & {16'd0, uimm}; rec = 1'b1; end
            OP_ANDIS: begin wr = 1'b1; widx = ra; wval = vs & {uimm, 16'd0}; rec = 1'b1; end
            OP_X: begin
                rec = rc;
                unique case (xo)
                    XO_CMP, XO_CMPL: begin
                        rec = 1'b0; crw = 1'b1; crf = r_ins[25:23];
                        crb = f_compare(va, vb, xo == XO_CMP);
                    end
                    XO_SUBF: begin wr = 1'b1; widx = rt; wval = vb - va; end
                    XO_NEG: begin wr = 1'b1; widx = rt; wval = 32'd0 - va; end
                    XO_ADD: begin wr = 1'b1; widx = rt; wval = va + vb; end
                    XO_MULLW: begin wr = 1'b1; widx = rt; wval = prod_lo; end
                    XO_MULHWU: begin wr = 1'b1; widx = rt; wval = prod_hi; end
                    XO_AND: begin wr = 1'b1; widx = ra; wval = vs & vb; end
                    XO_OR: begin wr = 1'b1; widx = ra; wval = vs | vb; end
                    XO_XOR: begin wr = 1'b1; widx = ra; wval = vs ^ vb; end
                    XO_EXTSB: begin wr = 1'b1; widx = ra; wval = {{24{vs[7]}}, vs[7:0]}; end
                    XO_EXTSH: begin wr = 1'b1; widx = ra; wval = {{16{vs[15]}}, vs[15:0]}; end
                    XO_SLW: begin
                        wr = 1'b1; widx = ra; wval = vb[5] ? 32'd0 : (vs << vb[4:0]);
                    end
                    XO_SRW: begin
                        wr = 1'b1; widx = ra; wval = vb[5] ? 32'd0 : (vs >> vb[4:0]);
                    end
                    XO_SRAW, XO_SRAWI: begin
                        wr = 1'b1; widx = ra; wval = sra_r; caw = 1'b1; cav = sra_c;
                    end
                    XO_CNTLZW: begin wr = 1'b1; widx = ra; wval = 32'(f_clz(vs)); end
                    default: begin unh = 1'b1; rec = 1'b0; end
                endcase
            end
            default: unh = 1'b1;
        endcase
        if (rec) begin
            crw = 1'b1; crf = 3'd0; crb = f_compare(wval, 32'd0, 1'b1);
        end
        res.reg_written = wr;
        res.reg_index = widx;
        res.reg_value = wval;
        res.cr_written = crw;
        res.cr_field = crf;
        res.cr_bits = crb;
        res.carry_written = caw;
        res.carry_value = cav;
        res.unhandled = unh;
        cr_mask = 32'hF000_0000 >> {crf, 2'b00};
    end

    // memory: sweep writes zero after reset, else stage 2 writeback
    logic        mem_we;
    logic [4:0]  mem_wa;
    logic [31:0] mem_wd;
    assign mem_we = clearing || (exec && wr);
    assign mem_wa = clearing ? r_clr[4:0] : widx;
    assign mem_wd = clearing ? 32'd0 : wval;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_t[mem_wa] <= mem_wd;
            r_mem_a[mem_wa] <= mem_wd;
            r_mem_b[mem_wa] <= mem_wd;
        end
        r_rd_t <= r_mem_t[s_axis_tdata[25:21]];
        r_rd_a <= r_mem_a[s_axis_tdata[20:16]];
        r_rd_b <= r_mem_b[s_axis_tdata[15:11]];
        if (take) r_ins <= s_axis_tdata;
        r_fw_idx <= widx;
        r_fw_val <= wval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= 6'd0;
            r_v1 <= 1'b0;
            r_fw_v <= 1'b0;
            r_carry <= 1'b0;
            r_cr <= 32'd0;
        end else begin
            if (clearing) r_clr <= r_clr + 6'd1;
            r_v1 <= take;
            // forward only when the write lands in the cycle the next read was stale
            r_fw_v <= exec && wr && take;
            if (exec && caw) r_carry <= cav;
            if (exec && crw) r_cr <= (r_cr & ~cr_mask) | ((32'(crb) << 28) >> {crf, 2'b00});
        end
    end

    // output queue: entry 0 is the head
    logic [1:0] n_cnt;
    assign n_cnt = r_cnt - 2'(pop) + 2'(exec);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q0_v <= 1'b0;
            r_q1_v <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            r_q0_v <= (n_cnt != 2'd0);
            r_q1_v <= (n_cnt == 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q0 <= r_q1_v ? r_q1 : res;
            if (exec && r_q1_v) r_q1 <= res;
        end else if (exec) begin
            if (r_q0_v) r_q1 <= res;
            else r_q0 <= res;
        end
    end

    assign m_axis_tvalid = r_q0_v;
    assign m_axis_tdata = {7'd0, r_q0};

    `PIEU_ASSERT_IMP(a_no_take_clear, i_clk, i_rst_n, clearing, !s_axis_tready,
        "word accepted during register clear")
    `PIEU_ASSERT_NEXT(a_queue_bound, i_clk, i_rst_n, exec, r_cnt != 2'd0,
        "result lost from output queue")
    `PIEU_ASSERT_IMP(a_q1_needs_q0, i_clk, i_rst_n, r_q1_v, r_q0_v,
        "second queue entry without head")
    `PIEU_ASSERT_IMP(a_one_kind, i_clk, i_rst_n, exec && res.unhandled,
        !res.reg_written && !res.cr_written && !res.carry_written,
        "unhandled instruction with side effects")
endmodule
